// File: hdl/srarq_pkg.sv
`default_nettype none
package srarq_pkg;

   localparam int SEQ_MAX      = 7;
   localparam int BUF_COUNT    = 4;
   localparam int PAYLOAD_BITS = 32;
   localparam int SEQ_BITS     = 3;
   localparam int SLOT_BITS    = $clog2(BUF_COUNT);
   localparam int CNT_BITS     = $clog2(BUF_COUNT + 1);
   localparam int QUEUE_DEPTH  = 2;

   typedef logic [SEQ_BITS-1:0]     seq_type;
   typedef logic [SLOT_BITS-1:0]    slot_type;
   typedef logic [CNT_BITS-1:0]     cnt_type;
   typedef logic [PAYLOAD_BITS-1:0] pay_type;

   // request codes on the input channel
   localparam logic [1:0] REQ_SEND    = 2'd0;
   localparam logic [1:0] REQ_FRAME   = 2'd1;
   localparam logic [1:0] REQ_CKSUM   = 2'd2;
   localparam logic [1:0] REQ_TIMEOUT = 2'd3;

   // frame kinds
   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_ACK  = 2'd1;
   localparam logic [1:0] KIND_NAK  = 2'd2;

   // result item kinds
   localparam logic [1:0] ITEM_TX      = 2'd0;
   localparam logic [1:0] ITEM_DELIVER = 2'd1;
   localparam logic [1:0] ITEM_STATUS  = 2'd2;

   localparam cnt_type BUF_LIMIT    = CNT_BITS'(BUF_COUNT);
   localparam seq_type WINDOW_RESET = SEQ_BITS'(BUF_COUNT % (SEQ_MAX + 1));

   typedef enum logic [2:0] {
      OP_SEND,
      OP_DATA,
      OP_NAK_FRAME,
      OP_ACK_FRAME,
      OP_CKSUM,
      OP_TIMEOUT
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DELIVER,
      ST_ACK_RELEASE,
      ST_STATUS
   } state_type;

   typedef struct packed {
      op_type  op;
      seq_type seq;
      seq_type ack;
      pay_type pay;
   } cmd_type;

   typedef struct packed {
      logic [1:0] item_kind;
      logic [1:0] tx_kind;
      seq_type    tx_seq;
      seq_type    tx_ack;
      pay_type    payload_out;
      logic       send_enabled;
      logic       request_refused;
      logic       last_item;
   } rsp_type;

   function automatic seq_type seq_next(seq_type k);
      return (k == SEQ_BITS'(SEQ_MAX)) ? '0 : k + 1'b1;
   endfunction

   function automatic seq_type seq_prev(seq_type k);
      return (k == '0) ? SEQ_BITS'(SEQ_MAX) : k - 1'b1;
   endfunction

   // a <= b < c, circularly
   function automatic logic in_window(seq_type a, seq_type b, seq_type c);
      return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
   endfunction

endpackage
`default_nettype wire

// File: hdl/srarq_front.sv
`default_nettype none
module srarq_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire  [1:0]            req_type,
   input  wire  [1:0]            req_rx_kind,
   input  srarq_pkg::seq_type    req_rx_seq,
   input  srarq_pkg::seq_type    req_rx_ack,
   input  srarq_pkg::pay_type    req_payload_in,
   output logic                  cmd_valid,
   output srarq_pkg::cmd_type    cmd,
   input  wire                   cmd_pop
);
   import srarq_pkg::*;

   cmd_type     queue_ff [QUEUE_DEPTH];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  fill_ff, fill_in;
   cmd_type     cls;
   logic        push;

   // classify the request
   always_comb begin
      cls.seq = req_rx_seq;
      cls.ack = req_rx_ack;
      cls.pay = req_payload_in;
      unique case (req_type)
         REQ_SEND:  cls.op = OP_SEND;
         REQ_CKSUM: cls.op = OP_CKSUM;
         REQ_FRAME: begin
            unique case (req_rx_kind)
               KIND_DATA: cls.op = OP_DATA;
               KIND_NAK:  cls.op = OP_NAK_FRAME;
               default:   cls.op = OP_ACK_FRAME;   // unknown kind acts as ack
            endcase
         end
         default:   cls.op = OP_TIMEOUT;
      endcase
   end

   assign req_stall = (fill_ff == 2'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (fill_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push    ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule
`default_nettype wire

// File: hdl/srarq_back.sv
`default_nettype none
module srarq_back (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   cmd_valid,
   input  srarq_pkg::cmd_type    cmd,
   output logic                  cmd_pop,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output srarq_pkg::rsp_type    rsp
);
   import srarq_pkg::*;

   state_type  state_ff, state_in;
   cmd_type    cur_ff, cur_in;
   seq_type    nss_ff, nss_in;
   seq_type    oldest_ff, oldest_in;
   seq_type    exp_ff, exp_in;
   seq_type    upper_ff, upper_in;
   cnt_type    count_ff, count_in;
   logic       nak_ok_ff, nak_ok_in;
   logic       refused_ff, refused_in;
   logic [BUF_COUNT-1:0] marks_ff, marks_in;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff, out_in;

   pay_type    send_store_ff [BUF_COUNT];
   pay_type    recv_store_ff [BUF_COUNT];
   logic       send_wr;
   slot_type   send_wr_slot;
   logic       recv_wr;
   slot_type   recv_wr_slot;

   logic       load;
   seq_type    nak_rs;
   seq_type    ack_dist;
   slot_type   exp_slot;
   slot_type   seq_slot;

   assign load      = !out_valid_ff || !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;
   assign nak_rs    = seq_next(cur_ff.ack);
   assign ack_dist  = cur_ff.ack - oldest_ff + 1'b1;
   assign exp_slot  = exp_ff[SLOT_BITS-1:0];
   assign seq_slot  = cur_ff.seq[SLOT_BITS-1:0];

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      nss_in       = nss_ff;
      oldest_in    = oldest_ff;
      exp_in       = exp_ff;
      upper_in     = upper_ff;
      count_in     = count_ff;
      nak_ok_in    = nak_ok_ff;
      refused_in   = refused_ff;
      marks_in     = marks_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_in       = out_ff;
      cmd_pop      = 1'b0;
      send_wr      = 1'b0;
      send_wr_slot = nss_ff[SLOT_BITS-1:0];
      recv_wr      = 1'b0;
      recv_wr_slot = seq_slot;

      if (load) begin
         out_in                 = '0;
         out_in.tx_ack          = seq_prev(exp_ff);
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd_valid) begin
                  cmd_pop    = 1'b1;
                  cur_in     = cmd;
                  refused_in = 1'b0;
                  state_in   = ST_EXEC;
               end
            end
            ST_EXEC: begin
               state_in = ST_STATUS;
               case (cur_ff.op)
                  OP_SEND: begin
                     if (count_ff < BUF_LIMIT) begin
                        send_wr            = 1'b1;
                        count_in           = count_ff + 1'b1;
                        out_valid_in       = 1'b1;
                        out_in.item_kind   = ITEM_TX;
                        out_in.tx_kind     = KIND_DATA;
                        out_in.tx_seq      = nss_ff;
                        out_in.payload_out = cur_ff.pay;
                        nss_in             = seq_next(nss_ff);
                     end else begin
                        refused_in = 1'b1;
                     end
                  end
                  OP_CKSUM: begin
                     if (nak_ok_ff) begin
                        out_valid_in     = 1'b1;
                        out_in.item_kind = ITEM_TX;
                        out_in.tx_kind   = KIND_NAK;
                        nak_ok_in        = 1'b0;
                     end
                  end
                  OP_TIMEOUT: begin
                     out_valid_in     = 1'b1;
                     out_in.item_kind = ITEM_TX;
                     out_in.tx_kind   = KIND_ACK;
                  end
                  OP_DATA: begin
                     if ((cur_ff.seq != exp_ff) && nak_ok_ff) begin
                        out_valid_in     = 1'b1;
                        out_in.item_kind = ITEM_TX;
                        out_in.tx_kind   = KIND_NAK;
                        nak_ok_in        = 1'b0;
                     end
                     if (in_window(exp_ff, cur_ff.seq, upper_ff) && !marks_ff[seq_slot]) begin
                        marks_in[seq_slot] = 1'b1;
                        recv_wr            = 1'b1;
                     end
                     state_in = ST_DELIVER;
                  end
                  OP_NAK_FRAME: begin
                     if (in_window(oldest_ff, nak_rs, nss_ff)) begin
                        out_valid_in       = 1'b1;
                        out_in.item_kind   = ITEM_TX;
                        out_in.tx_kind     = KIND_DATA;
                        out_in.tx_seq      = nak_rs;
                        out_in.payload_out = send_store_ff[nak_rs[SLOT_BITS-1:0]];
                     end
                     state_in = ST_ACK_RELEASE;
                  end
                  default: state_in = ST_ACK_RELEASE;
               endcase
            end
            ST_DELIVER: begin
               if (marks_ff[exp_slot]) begin
                  out_valid_in       = 1'b1;
                  out_in.item_kind   = ITEM_DELIVER;
                  out_in.tx_ack      = '0;
                  out_in.payload_out = recv_store_ff[exp_slot];
                  marks_in[exp_slot] = 1'b0;
                  nak_ok_in          = 1'b1;
                  exp_in             = seq_next(exp_ff);
                  upper_in           = seq_next(upper_ff);
               end else begin
                  state_in = ST_ACK_RELEASE;
               end
            end
            ST_ACK_RELEASE: begin
               // release every frame up to and including the ack at once
               if (in_window(oldest_ff, cur_ff.ack, nss_ff)) begin
                  count_in  = (count_ff > CNT_BITS'(ack_dist))
                              ? count_ff - CNT_BITS'(ack_dist) : '0;
                  oldest_in = seq_next(cur_ff.ack);
               end
               state_in = ST_STATUS;
            end
            ST_STATUS: begin
               out_valid_in           = 1'b1;
               out_in.item_kind       = ITEM_STATUS;
               out_in.tx_ack          = '0;
               out_in.send_enabled    = (count_ff < BUF_LIMIT);
               out_in.request_refused = refused_ff;
               out_in.last_item       = 1'b1;
               state_in               = ST_IDLE;
            end
            default: state_in = ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         nss_ff       <= '0;
         oldest_ff    <= '0;
         exp_ff       <= '0;
         upper_ff     <= WINDOW_RESET;
         count_ff     <= '0;
         nak_ok_ff    <= 1'b1;
         refused_ff   <= 1'b0;
         marks_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nss_ff       <= nss_in;
         oldest_ff    <= oldest_in;
         exp_ff       <= exp_in;
         upper_ff     <= upper_in;
         count_ff     <= count_in;
         nak_ok_ff    <= nak_ok_in;
         refused_ff   <= refused_in;
         marks_ff     <= marks_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      out_ff <= out_in;
      if (send_wr) begin
         send_store_ff[send_wr_slot] <= cur_ff.pay;
      end
      if (recv_wr) begin
         recv_store_ff[recv_wr_slot] <= cur_ff.pay;
      end
   end

endmodule
`default_nettype wire

// File: hdl/selective_repeat_arq_station.sv
// Selective-repeat ARQ endpoint.
// Input channel (req_*): one item per event - send a new packet, a frame
// has arrived (kind, seq, piggyback ack, data), a checksum error, or an
// ack timeout. Result channel (rsp_*): a stream of items per event -
// transmit frames, in-order deliveries - always closed by one status item
// with rsp_last_item set.
// Both channels use valid/stall; an item moves when valid is high and
// stall is low.
// The front classifies events into a two-entry queue; the back sequencer
// runs them one at a time, at most one result item a cycle. Steps: idle,
// exec, status for send/checksum/timeout; ack-release before status for
// an ack or nak frame; a deliver step per delivered packet plus a final
// one, then ack-release, for a data frame. A transmitted frame is output
// from exec; the status item closes the event in its last sequencer step.
// Reset clears windows, counters, arrival marks and the queue; the buffers
// are left as they are. A stalled receiver freezes the sequencer; the
// front keeps taking items until its queue is full.
`default_nettype none
module selective_repeat_arq_station (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire  [1:0]            req_type,
   input  wire  [1:0]            req_rx_kind,
   input  wire  [2:0]            req_rx_seq,
   input  wire  [2:0]            req_rx_ack,
   input  wire  [31:0]           req_payload_in,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output logic [1:0]            rsp_item_kind,
   output logic [1:0]            rsp_tx_kind,
   output logic [2:0]            rsp_tx_seq,
   output logic [2:0]            rsp_tx_ack,
   output logic [31:0]           rsp_payload_out,
   output logic                  rsp_send_enabled,
   output logic                  rsp_request_refused,
   output logic                  rsp_last_item
);
   import srarq_pkg::*;

   logic     cmd_valid;
   logic     cmd_pop;
   cmd_type  cmd;
   rsp_type  rsp;

   // event classifier and queue
   srarq_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_rx_kind    (req_rx_kind),
      .req_rx_seq     (req_rx_seq),
      .req_rx_ack     (req_rx_ack),
      .req_payload_in (req_payload_in),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_pop        (cmd_pop)
   );

   // window state, buffers and result sequencer
   srarq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_item_kind       = rsp.item_kind;
   assign rsp_tx_kind         = rsp.tx_kind;
   assign rsp_tx_seq          = rsp.tx_seq;
   assign rsp_tx_ack          = rsp.tx_ack;
   assign rsp_payload_out     = rsp.payload_out;
   assign rsp_send_enabled    = rsp.send_enabled;
   assign rsp_request_refused = rsp.request_refused;
   assign rsp_last_item       = rsp.last_item;

endmodule
`default_nettype wire
